### hw/rtl/lb64u_pkg.sv
// Package for the lenient base64url decoder: character map, result group type.
// No dependencies; imported by lb64u_step and the top level.
`default_nettype none

package lb64u_pkg;

    localparam int unsigned CharW   = 8;
    localparam int unsigned ByteW   = 8;
    localparam int unsigned SextetW = 6;
    localparam int unsigned HeldW   = 3 * SextetW;
    localparam int unsigned GroupN  = 3;
    localparam int unsigned IdxW    = 2;

    localparam logic [SextetW-1:0] SextetDash  = 6'd62;
    localparam logic [SextetW-1:0] SextetSlash = 6'd63;
    localparam logic [SextetW-1:0] LowerBase   = 6'd26;
    localparam logic [SextetW-1:0] DigitBase   = 6'd52;

    localparam logic [1:0] CountNone  = 2'd0;
    localparam logic [1:0] CountTwo   = 2'd2;
    localparam logic [1:0] CountThree = 2'd3;

    typedef struct packed {
        logic               ok;
        logic [SextetW-1:0] value;
    } sextet_t;

    // Up to three bytes caused by one input transaction
    typedef struct packed {
        logic [GroupN-1:0][ByteW-1:0] bytes;
        logic [IdxW-1:0]              last_idx;
        logic                         byte_valid;
        logic                         stream_end;
    } group_t;

    // Map a character of either alphabet to its sextet; flag everything else
    function automatic sextet_t sextet_of(input logic [CharW-1:0] ch);
        sextet_t r;
        r.ok    = 1'b1;
        r.value = '0;
        if (ch >= 8'h41 && ch <= 8'h5A)
        begin
            r.value = SextetW'(ch - 8'h41);
        end
        else if (ch >= 8'h61 && ch <= 8'h7A)
        begin
            r.value = SextetW'(ch - 8'h61) + LowerBase;
        end
        else if (ch >= 8'h30 && ch <= 8'h39)
        begin
            r.value = SextetW'(ch - 8'h30) + DigitBase;
        end
        else if (ch == 8'h2D || ch == 8'h2B)
        begin
            r.value = SextetDash;
        end
        else if (ch == 8'h5F || ch == 8'h2F)
        begin
            r.value = SextetSlash;
        end
        else
        begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/lb64u_if.sv
// Channel interfaces of the lenient base64url decoder: characters in, bytes out.
// Depends on nothing.
`default_nettype none

interface lb64u_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       has_char;
    logic       end_of_text;

    modport source (output valid, output char_code, output has_char,
                    output end_of_text, input ready);
    modport sink   (input valid, input char_code, input has_char,
                    input end_of_text, output ready);
endinterface

interface lb64u_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       stream_end;

    modport source (output valid, output data_byte, output byte_valid,
                    output last_of_run, output stream_end, input ready);
    modport sink   (input valid, input data_byte, input byte_valid,
                    input last_of_run, input stream_end, output ready);
endinterface

`default_nettype wire

### hw/rtl/lenient_base64url_decoder_unit.sv
// Top level of the lenient base64url decoder: sextet state and result buffer.
// Depends on lb64u_pkg, lb64u_if and lb64u_step.
//
//  channel  dir  payload                                      role
//  chars    in   char_code, has_char, end_of_text             one text char
//  bytes    out  data_byte, byte_valid, last_of_run, stream_end  one result
//
// A character is decoded in the cycle it is accepted; its results sit in a
// group register and leave one per cycle while the output is ready, so a
// character can be taken every cycle while each holds at most one result
// and the output is ready. A character that completes a group occupies the
// group register until its three results have left and stalls the input meanwhile.
// The input is taken in the cycle the last buffered result leaves.
// Reset clears the sextet state and empties the buffer.
`default_nettype none

module lenient_base64url_decoder_unit
    import lb64u_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    lb64u_char_if.sink   chars,
    lb64u_byte_if.source bytes
);

    logic [HeldW-1:0] held_reg;
    logic [HeldW-1:0] held_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    group_t           grp_reg;
    group_t           grp_next;
    logic             grp_valid_reg;
    logic             grp_valid_next;
    logic [IdxW-1:0]  idx_reg;
    logic [IdxW-1:0]  idx_next;
    logic             emit;
    logic             in_fire;
    logic             out_fire;
    logic             at_last;

    lb64u_step u_step (
        .char_code   (chars.char_code),
        .has_char    (chars.has_char),
        .end_of_text (chars.end_of_text),
        .held        (held_reg),
        .count       (count_reg),
        .held_out    (held_next),
        .count_out   (count_next),
        .emit        (emit),
        .grp         (grp_next)
    );

    // Handshakes
    assign at_last     = (idx_reg == grp_reg.last_idx);
    assign out_fire    = grp_valid_reg && bytes.ready;
    assign chars.ready = !grp_valid_reg || (bytes.ready && at_last);
    assign in_fire     = chars.valid && chars.ready;

    // Select the current result
    always_comb
    begin
        unique case (idx_reg)
            2'd1:    bytes.data_byte = grp_reg.bytes[1];
            2'd2:    bytes.data_byte = grp_reg.bytes[2];
            default: bytes.data_byte = grp_reg.bytes[0];
        endcase
    end

    assign bytes.valid       = grp_valid_reg;
    assign bytes.byte_valid  = grp_reg.byte_valid;
    assign bytes.last_of_run = at_last;
    assign bytes.stream_end  = at_last && grp_reg.stream_end;

    // Advance the buffer: load a new group, step to the next byte, or drop it
    always_comb
    begin
        grp_valid_next = grp_valid_reg;
        idx_next       = idx_reg;
        if (in_fire)
        begin
            grp_valid_next = emit;
            idx_next       = '0;
        end
        else if (out_fire)
        begin
            if (at_last)
            begin
                grp_valid_next = 1'b0;
                idx_next       = '0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    // Control and sextet state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            count_reg     <= CountNone;
            grp_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            grp_valid_reg <= grp_valid_next;
            idx_reg       <= idx_next;
            if (in_fire)
            begin
                held_reg  <= held_next;
                count_reg <= count_next;
            end
        end
    end

    // Result payload, loaded with each transaction that emits
    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            grp_reg <= grp_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lb64u_step.sv
// Per-character decode step: next sextet state and the result group it causes.
// Depends on lb64u_pkg.
`default_nettype none

module lb64u_step
    import lb64u_pkg::*;
(
    input  wire logic [CharW-1:0] char_code,
    input  wire logic             has_char,
    input  wire logic             end_of_text,
    input  wire logic [HeldW-1:0] held,
    input  wire logic [1:0]       count,
    output logic      [HeldW-1:0] held_out,
    output logic      [1:0]       count_out,
    output logic                  emit,
    output group_t                grp
);

    sextet_t              sx;
    logic                 keep;
    logic [HeldW+5:0]     acc;
    logic [HeldW-1:0]     held_mid;
    logic [1:0]           count_mid;
    logic                 full;

    assign sx   = sextet_of(char_code);
    assign keep = has_char && sx.ok;
    assign acc  = {held, sx.value};
    assign full = keep && (count == CountThree);

    // Shift the kept sextet in, or complete a group
    always_comb
    begin
        if (full)
        begin
            held_mid  = '0;
            count_mid = CountNone;
        end
        else if (keep)
        begin
            held_mid  = acc[HeldW-1:0];
            count_mid = count + 2'd1;
        end
        else
        begin
            held_mid  = held;
            count_mid = count;
        end
    end

    // Build the result group, then flush leftovers at the end of the text
    always_comb
    begin
        grp.bytes      = '0;
        grp.last_idx   = 2'd0;
        grp.byte_valid = 1'b1;
        grp.stream_end = end_of_text;
        emit           = 1'b0;
        held_out       = held_mid;
        count_out      = count_mid;
        if (full)
        begin
            grp.bytes[0] = acc[23:16];
            grp.bytes[1] = acc[15:8];
            grp.bytes[2] = acc[7:0];
            grp.last_idx = 2'd2;
            emit         = 1'b1;
        end
        if (end_of_text)
        begin
            emit      = 1'b1;
            held_out  = '0;
            count_out = CountNone;
            if (!full)
            begin
                priority if (count_mid == CountTwo)
                begin
                    grp.bytes[0] = held_mid[11:4];
                end
                else if (count_mid == CountThree)
                begin
                    grp.bytes[0] = held_mid[17:10];
                    grp.bytes[1] = held_mid[9:2];
                    grp.last_idx = 2'd1;
                end
                else
                begin
                    grp.byte_valid = 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire
